@@ design/smrl_pkg.sv @@
// ----------------------------------------------------------------------------
// smrl_pkg: shared definitions for the set membership run length block
//
// Store depths, derived widths, item codes, status codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package smrl_pkg;

   // Store depths.
   localparam int ARRAY_DEPTH = 1024;
   localparam int SET_DEPTH   = 64;

   // Fixed field widths of the channels.
   localparam int MODE_W  = 2;
   localparam int VALUE_W = 32;
   localparam int START_W = 10;
   localparam int SPAN_W  = 11;
   localparam int STAT_W  = 2;

   // Widths that follow from the store depths.
   localparam int AIDX_W = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int ACNT_W = $clog2(ARRAY_DEPTH + 1);
   localparam int SIDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int SCNT_W = $clog2(SET_DEPTH + 1);

   // Item codes.
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADDSET = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // Status codes of a query result.
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARR_RD,
      ST_SCAN,
      ST_DELIVER
   } state_type;

endpackage

@@ design/smrl_req_if.sv @@
// ----------------------------------------------------------------------------
// smrl_req_if: request channel
//
// Carries load, set, query and clear items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smrl_req_if;
   logic                                valid;
   logic                                ready;
   logic [smrl_pkg::MODE_W-1:0]         mode;
   logic signed [smrl_pkg::VALUE_W-1:0] value;
   logic [smrl_pkg::START_W-1:0]        start_position;

   modport source (output valid, output mode, output value, output start_position,
                   input ready);
   modport sink   (input valid, input mode, input value, input start_position,
                   output ready);
endinterface

@@ design/smrl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// smrl_rsp_if: response channel
//
// Carries query results with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smrl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [smrl_pkg::SPAN_W-1:0] span_length;
   logic [smrl_pkg::STAT_W-1:0] status;

   modport source (output valid, output span_length, output status, input ready);
   modport sink   (input valid, input span_length, input status, output ready);
endinterface

@@ design/set_membership_run_length.sv @@
// ----------------------------------------------------------------------------
// set_membership_run_length: span of allowed values in a loaded array
//
// Append and clear finish on acceptance. Add-set runs a duplicate check, streaming
// the set through one shared 32-bit comparator, one value per cycle. Query reads
// each scanned element from the array and compares it against the set values until
// a match, and may wait for an unread earlier result. Not ready while busy. Reset
// clears counts, flag, sequencer.
// ----------------------------------------------------------------------------
module set_membership_run_length (
   input  logic        clock,
   input  logic        reset,
   smrl_req_if.sink    req_ch,
   smrl_rsp_if.source  rsp_ch
);

   // Sequencer and control registers.
   smrl_pkg::state_type state_ff, state_in;
   logic                            op_query_ff, op_query_in;
   logic                            past_ff, past_in;
   logic                            pend_ff, pend_in;
   logic                            ovf_ff, ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [smrl_pkg::SCNT_W-1:0]     k_ff, k_in;
   logic [smrl_pkg::ACNT_W-1:0]     array_count_ff, array_count_in;
   logic [smrl_pkg::SCNT_W-1:0]     set_count_ff, set_count_in;
   logic [smrl_pkg::AIDX_W-1:0]     arr_idx_ff, arr_idx_in;
   logic [smrl_pkg::ACNT_W-1:0]     span_ff, span_in;

   // Payload registers.
   logic signed [smrl_pkg::VALUE_W-1:0] val_ff, val_in;
   logic signed [smrl_pkg::VALUE_W-1:0] arr_rdata_ff;
   logic signed [smrl_pkg::VALUE_W-1:0] set_rdata_ff;
   logic [smrl_pkg::SPAN_W-1:0]         rsp_span_ff, rsp_span_in;
   logic [smrl_pkg::STAT_W-1:0]         rsp_status_ff, rsp_status_in;

   // Stores.
   logic signed [smrl_pkg::VALUE_W-1:0] array_mem [smrl_pkg::ARRAY_DEPTH];
   logic signed [smrl_pkg::VALUE_W-1:0] set_mem   [smrl_pkg::SET_DEPTH];

   // Decoded control.
   logic                                accept;
   logic                                arr_we, arr_re, set_we, set_re;
   logic                                arr_full, set_full;
   logic                                hit, exhausted, span_last, deliver_go;
   logic                                past_end;
   logic signed [smrl_pkg::VALUE_W-1:0] key;

   // Handshake and shared comparator.
   always_comb begin
      accept     = req_ch.valid && (state_ff == smrl_pkg::ST_IDLE);
      arr_full   = array_count_ff >= smrl_pkg::ACNT_W'(smrl_pkg::ARRAY_DEPTH);
      set_full   = set_count_ff >= smrl_pkg::SCNT_W'(smrl_pkg::SET_DEPTH);
      past_end   = 32'(req_ch.start_position) >= 32'(array_count_ff);
      key        = op_query_ff ? arr_rdata_ff : val_ff;
      hit        = pend_ff && (set_rdata_ff == key);
      exhausted  = !pend_ff && (k_ff >= set_count_ff);
      span_last  = (smrl_pkg::ACNT_W'(arr_idx_ff) + smrl_pkg::ACNT_W'(1)) >= array_count_ff;
      deliver_go = (state_ff == smrl_pkg::ST_DELIVER) && (!rsp_valid_ff || rsp_ch.ready);
      arr_we     = accept && (req_ch.mode == smrl_pkg::MODE_APPEND) && !arr_full;
      arr_re     = (state_ff == smrl_pkg::ST_ARR_RD);
      set_re     = (state_ff == smrl_pkg::ST_SCAN) && (k_ff < set_count_ff);
      set_we     = (state_ff == smrl_pkg::ST_SCAN) && !op_query_ff && !hit && exhausted
                   && !set_full;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smrl_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == smrl_pkg::MODE_ADDSET) begin
                  state_in = smrl_pkg::ST_SCAN;
               end else if (req_ch.mode == smrl_pkg::MODE_QUERY) begin
                  state_in = past_end ? smrl_pkg::ST_DELIVER : smrl_pkg::ST_ARR_RD;
               end
            end
         end
         smrl_pkg::ST_ARR_RD: begin
            state_in = smrl_pkg::ST_SCAN;
         end
         smrl_pkg::ST_SCAN: begin
            if (hit) begin
               if (!op_query_ff) begin
                  state_in = smrl_pkg::ST_IDLE;
               end else if (span_last) begin
                  state_in = smrl_pkg::ST_DELIVER;
               end else begin
                  state_in = smrl_pkg::ST_ARR_RD;
               end
            end else if (exhausted) begin
               state_in = op_query_ff ? smrl_pkg::ST_DELIVER : smrl_pkg::ST_IDLE;
            end
         end
         smrl_pkg::ST_DELIVER: begin
            if (deliver_go) begin
               state_in = smrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smrl_pkg::ST_IDLE;
         end
      endcase
   end

   // Register updates driven by the sequencer.
   always_comb begin
      op_query_in    = op_query_ff;
      past_in        = past_ff;
      val_in         = val_ff;
      arr_idx_in     = arr_idx_ff;
      span_in        = span_ff;
      array_count_in = array_count_ff;
      set_count_in   = set_count_ff;
      ovf_in         = ovf_ff;
      pend_in        = set_re;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_span_in    = rsp_span_ff;
      rsp_status_in  = rsp_status_ff;

      // A new item latches its operands and restarts the scan counters.
      if (accept) begin
         op_query_in = (req_ch.mode == smrl_pkg::MODE_QUERY);
         past_in     = past_end;
         val_in      = req_ch.value;
         arr_idx_in  = smrl_pkg::AIDX_W'(req_ch.start_position);
         span_in     = '0;
         k_in        = '0;
         case (req_ch.mode)
            smrl_pkg::MODE_APPEND: begin
               if (arr_full) begin
                  ovf_in = 1'b1;
               end else begin
                  array_count_in = array_count_ff + smrl_pkg::ACNT_W'(1);
               end
            end
            smrl_pkg::MODE_CLEAR: begin
               array_count_in = '0;
               ovf_in         = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // Each array read restarts the set scan for the next element.
      if (arr_re) begin
         k_in = '0;
      end else if (set_re) begin
         k_in = k_ff + smrl_pkg::SCNT_W'(1);
      end

      // A matching element extends the span.
      if ((state_ff == smrl_pkg::ST_SCAN) && hit && op_query_ff) begin
         span_in    = span_ff + smrl_pkg::ACNT_W'(1);
         arr_idx_in = arr_idx_ff + smrl_pkg::AIDX_W'(1);
      end

      // A new set value is stored, or flagged when the set is full.
      if ((state_ff == smrl_pkg::ST_SCAN) && !op_query_ff && !hit && exhausted) begin
         if (set_full) begin
            ovf_in = 1'b1;
         end else begin
            set_count_in = set_count_ff + smrl_pkg::SCNT_W'(1);
         end
      end

      // The result moves to the output register and the set is emptied.
      if (deliver_go) begin
         rsp_valid_in = 1'b1;
         rsp_span_in  = smrl_pkg::SPAN_W'(span_ff);
         if (past_ff) begin
            rsp_status_in = smrl_pkg::STAT_PAST_END;
         end else if (ovf_ff) begin
            rsp_status_in = smrl_pkg::STAT_OVERFLOW;
         end else begin
            rsp_status_in = smrl_pkg::STAT_OK;
         end
         set_count_in = '0;
         ovf_in       = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= smrl_pkg::ST_IDLE;
         op_query_ff    <= 1'b0;
         past_ff        <= 1'b0;
         pend_ff        <= 1'b0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         k_ff           <= '0;
         array_count_ff <= '0;
         set_count_ff   <= '0;
         arr_idx_ff     <= '0;
         span_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         op_query_ff    <= op_query_in;
         past_ff        <= past_in;
         pend_ff        <= pend_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         k_ff           <= k_in;
         array_count_ff <= array_count_in;
         set_count_ff   <= set_count_in;
         arr_idx_ff     <= arr_idx_in;
         span_ff        <= span_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Array memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (arr_we) begin
         array_mem[array_count_ff[smrl_pkg::AIDX_W-1:0]] <= req_ch.value;
      end
      if (arr_re) begin
         arr_rdata_ff <= array_mem[arr_idx_ff];
      end
   end

   // Set memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (set_we) begin
         set_mem[set_count_ff[smrl_pkg::SIDX_W-1:0]] <= val_ff;
      end
      if (set_re) begin
         set_rdata_ff <= set_mem[k_ff[smrl_pkg::SIDX_W-1:0]];
      end
   end

   // Channel outputs.
   assign req_ch.ready       = (state_ff == smrl_pkg::ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.span_length = rsp_span_ff;
   assign rsp_ch.status      = rsp_status_ff;

   // A query only ever scans elements that are held in the array.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smrl_pkg::ST_SCAN && op_query_ff)
      |-> (smrl_pkg::ACNT_W'(arr_idx_ff) < array_count_ff))
      else $error("query scan index beyond array end");

   // The set never holds more values than it has room for.
   a_set_bound: assert property (@(posedge clock) disable iff (reset)
      set_count_ff <= smrl_pkg::SCNT_W'(smrl_pkg::SET_DEPTH))
      else $error("set count above set depth");

   // A finished query is presented in the next cycle and empties the set.
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      deliver_go |=> (rsp_valid_ff && set_count_ff == '0 && !ovf_ff))
      else $error("finished query not presented");

   // A start past the array end always reports an empty span.
   a_past_end_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == smrl_pkg::STAT_PAST_END) |-> (rsp_span_ff == '0))
      else $error("past-end result with non-zero span");

endmodule

@@ verif/set_membership_run_length_tb.sv @@
// ----------------------------------------------------------------------------
// set_membership_run_length_tb: self-checking bench for the run length block
//
// A queue of pending items, filled by the stimulus process, feeds a clocked
// driver on the request channel. Every accepted item is applied to a local
// image of the array, the allowed set and the overflow flag, and each query
// leaves an expected span and status behind. A clocked collector on the
// response channel checks every transfer against the oldest expectation.
// Both channels idle at random, and a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module set_membership_run_length_tb;

   // Run sizes and limits.
   localparam int ITEM_TARGET    = 1530;
   localparam int QUERY_CYCLES   = (smrl_pkg::ARRAY_DEPTH + 1) * (smrl_pkg::SET_DEPTH + 2) + 2;
   localparam int WATCHDOG_LIMIT = 4 * (QUERY_CYCLES + 2 * 40 + 16);
   localparam int DRAIN_CYCLES   = 2 * (smrl_pkg::SET_DEPTH + 2) + 8;

   typedef struct packed {
      logic [smrl_pkg::MODE_W-1:0]         mode;
      logic signed [smrl_pkg::VALUE_W-1:0] value;
      logic [smrl_pkg::START_W-1:0]        start;
   } smrl_item_type;

   typedef struct packed {
      logic [smrl_pkg::SPAN_W-1:0] span;
      logic [smrl_pkg::STAT_W-1:0] status;
   } span_result_type;

   logic clock;
   logic reset;

   smrl_req_if req_ch ();
   smrl_rsp_if rsp_ch ();

   set_membership_run_length i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Items waiting to be driven and spans waiting to be returned.
   smrl_item_type   item_backlog [$];
   span_result_type span_expect [$];

   // Local image of the block's state.
   logic [smrl_pkg::VALUE_W-1:0] array_image [smrl_pkg::ARRAY_DEPTH];
   logic [smrl_pkg::VALUE_W-1:0] allowed_image [smrl_pkg::SET_DEPTH];
   int                           array_len;
   int                           allowed_len;
   bit                           overflow_flag;

   // Stimulus bookkeeping.
   logic [smrl_pkg::VALUE_W-1:0] value_pool [8];
   logic [smrl_pkg::VALUE_W-1:0] fill_vals [4];
   int                           gen_len;
   int                           queued_items;

   // Channel pacing and checking.
   smrl_item_type cur_item;
   int            send_gap;
   int            send_quiet;
   int            hold_gap;
   int            recv_quiet;
   int            idle_cycles;
   int            error_count;

   // Clock with a 20 unit period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, now and then long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit is_allowed(logic [smrl_pkg::VALUE_W-1:0] v);
      for (int k = 0; k < allowed_len; k++) begin
         if (allowed_image[k] == v) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one accepted item to the state image; a query leaves its span behind.
   task automatic predict_span(input smrl_item_type it);
      span_result_type r;
      int              pos;
      case (it.mode)
         smrl_pkg::MODE_APPEND: begin
            if (array_len < smrl_pkg::ARRAY_DEPTH) begin
               array_image[array_len] = it.value;
               array_len++;
            end else begin
               overflow_flag = 1'b1;
            end
         end
         smrl_pkg::MODE_ADDSET: begin
            if (!is_allowed(it.value)) begin
               if (allowed_len < smrl_pkg::SET_DEPTH) begin
                  allowed_image[allowed_len] = it.value;
                  allowed_len++;
               end else begin
                  overflow_flag = 1'b1;
               end
            end
         end
         smrl_pkg::MODE_CLEAR: begin
            array_len     = 0;
            overflow_flag = 1'b0;
         end
         smrl_pkg::MODE_QUERY: begin
            r.span = '0;
            if (int'(it.start) >= array_len) begin
               r.status = smrl_pkg::STAT_PAST_END;
            end else begin
               pos = int'(it.start);
               while (pos < array_len && is_allowed(array_image[pos])) begin
                  r.span = r.span + 1'b1;
                  pos++;
               end
               r.status = overflow_flag ? smrl_pkg::STAT_OVERFLOW : smrl_pkg::STAT_OK;
            end
            allowed_len   = 0;
            overflow_flag = 1'b0;
            span_expect   = {span_expect, r};
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Queue one item and keep track of the array length it leaves.
   task automatic push_item(input logic [smrl_pkg::MODE_W-1:0] mode,
                            input logic [smrl_pkg::VALUE_W-1:0] value,
                            input int start);
      smrl_item_type it;
      it.mode      = mode;
      it.value     = value;
      it.start     = smrl_pkg::START_W'(start);
      item_backlog = {item_backlog, it};
      queued_items++;
      if (mode == smrl_pkg::MODE_APPEND && gen_len < smrl_pkg::ARRAY_DEPTH) gen_len++;
      if (mode == smrl_pkg::MODE_CLEAR) gen_len = 0;
   endtask

   task automatic refresh_pool();
      for (int k = 0; k < 8; k++) begin
         case ($urandom_range(0, 5))
            0:       value_pool[k] = 32'h8000_0000;
            1:       value_pool[k] = 32'h7FFF_FFFF;
            2:       value_pool[k] = 32'hFFFF_FFFF;
            3:       value_pool[k] = $urandom_range(0, 15);
            default: value_pool[k] = $urandom;
         endcase
      end
   endtask

   function automatic logic [smrl_pkg::VALUE_W-1:0] pool_value();
      if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Query with a start that mostly lies inside the array.
   task automatic push_query(input int in_range_pct);
      int start;
      if (gen_len > 0 && $urandom_range(0, 99) < in_range_pct) begin
         start = $urandom_range(0, gen_len - 1);
      end else begin
         start = $urandom_range(0, 1023);
      end
      push_item(smrl_pkg::MODE_QUERY, $urandom, start);
   endtask

   // Hold the sender back until every item is taken and every span is back.
   task automatic wait_drained();
      while (item_backlog.size() != 0 || req_ch.valid || span_expect.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: present the next pending item after a random gap.
   always @(posedge clock) begin : drive_proc
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap   = 0;
         send_quiet = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_span(cur_item);
         next_valid = req_ch.valid;
         if (!req_ch.valid || req_ch.ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (item_backlog.size() > 0) begin
               cur_item = item_backlog.pop_front();
               req_ch.mode           <= cur_item.mode;
               req_ch.value          <= cur_item.value;
               req_ch.start_position <= cur_item.start;
               next_valid = 1'b1;
               if (send_quiet > 0) begin
                  send_quiet--;
                  send_gap = 0;
               end else begin
                  send_gap = draw_gap();
                  if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(20, 80);
               end
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   // Response collector: check each transfer, stall ready at random.
   always @(posedge clock) begin : collect_proc
      span_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_gap   = 0;
         recv_quiet = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (span_expect.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result with no prediction waiting: span %0d, status %0d",
                           rsp_ch.span_length, rsp_ch.status);
               end
            end else begin
               want = span_expect.pop_front();
               if (rsp_ch.span_length !== want.span) begin
                  report_mismatch("span_length", int'(want.span), int'(rsp_ch.span_length));
               end
               if (rsp_ch.status !== want.status) begin
                  report_mismatch("status", int'(want.status), int'(rsp_ch.status));
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (recv_quiet > 0) begin
               recv_quiet--;
            end else if ($urandom_range(0, 9) == 0) begin
               hold_gap = draw_gap();
            end else if ($urandom_range(0, 199) == 0) begin
               recv_quiet = $urandom_range(50, 300);
            end
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus_proc
      int kind;
      int count;
      int base;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.mode           = smrl_pkg::MODE_APPEND;
      req_ch.value          = '0;
      req_ch.start_position = '0;
      rsp_ch.ready          = 1'b0;
      array_len     = 0;
      allowed_len   = 0;
      overflow_flag = 1'b0;
      gen_len       = 0;
      queued_items  = 0;
      idle_cycles   = 0;
      error_count   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty array, extreme values, duplicates, absent start, past end.
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 0);
      push_item(smrl_pkg::MODE_APPEND, 32'h8000_0000, 0);
      push_item(smrl_pkg::MODE_APPEND, 32'h7FFF_FFFF, 1023);
      push_item(smrl_pkg::MODE_APPEND, 32'h0000_0000, 0);
      push_item(smrl_pkg::MODE_APPEND, 32'hFFFF_FFFF, 1023);
      push_item(smrl_pkg::MODE_ADDSET, 32'h8000_0000, 0);
      push_item(smrl_pkg::MODE_ADDSET, 32'h7FFF_FFFF, 0);
      push_item(smrl_pkg::MODE_ADDSET, 32'h8000_0000, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 1023);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 4);
      push_item(smrl_pkg::MODE_ADDSET, 32'hFFFF_FFFF, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 3);
      push_item(smrl_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 1023);
      push_item(smrl_pkg::MODE_APPEND, 32'd5, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 0);
      push_item(smrl_pkg::MODE_ADDSET, 32'd5, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 0);
      push_item(smrl_pkg::MODE_QUERY, 32'h0, 1);
      wait_drained();

      // Full array: overflow on both stores, then a span over every element.
      fill_vals[0] = 32'h8000_0000;
      fill_vals[1] = 32'h7FFF_FFFF;
      fill_vals[2] = 32'hFFFF_FFFF;
      fill_vals[3] = $urandom_range(0, 32'h00FF_FFFF);
      push_item(smrl_pkg::MODE_CLEAR, $urandom, $urandom);
      repeat (smrl_pkg::ARRAY_DEPTH) begin
         push_item(smrl_pkg::MODE_APPEND, fill_vals[$urandom_range(0, 3)], $urandom);
      end
      push_item(smrl_pkg::MODE_APPEND, $urandom, $urandom);
      for (int k = 0; k < 4; k++) push_item(smrl_pkg::MODE_ADDSET, fill_vals[k], $urandom);
      for (int k = 0; k < smrl_pkg::SET_DEPTH - 4; k++) begin
         push_item(smrl_pkg::MODE_ADDSET, 32'h1000_0000 + k, $urandom);
      end
      push_item(smrl_pkg::MODE_ADDSET, 32'h2000_0000, $urandom);
      push_item(smrl_pkg::MODE_ADDSET, fill_vals[0], $urandom);
      push_item(smrl_pkg::MODE_QUERY, $urandom, 0);
      for (int k = 0; k < 4; k++) push_item(smrl_pkg::MODE_ADDSET, fill_vals[k], $urandom);
      push_item(smrl_pkg::MODE_QUERY, $urandom, $urandom_range(0, 1023));
      repeat (6) begin
         repeat ($urandom_range(1, 3)) begin
            push_item(smrl_pkg::MODE_ADDSET, fill_vals[$urandom_range(0, 3)], 0);
         end
         push_item(smrl_pkg::MODE_QUERY, $urandom, $urandom_range(0, 1023));
      end

      // Random sequences: mostly load, set and query runs, some noise and overflow.
      while (queued_items < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         refresh_pool();
         if (kind < 70) begin
            if ($urandom_range(0, 1)) push_item(smrl_pkg::MODE_CLEAR, $urandom, $urandom);
            count = $urandom_range(0, 24);
            repeat (count) push_item(smrl_pkg::MODE_APPEND, pool_value(), $urandom);
            count = $urandom_range(0, 6);
            repeat (count) push_item(smrl_pkg::MODE_ADDSET, pool_value(), $urandom);
            push_query(80);
         end else if (kind < 88) begin
            count = $urandom_range(1, 8);
            repeat (count) begin
               push_item(smrl_pkg::MODE_W'($urandom_range(0, 3)), $urandom,
                         $urandom_range(0, 1023));
            end
         end else begin
            // The set is driven past its depth before the query.
            base  = $urandom;
            count = $urandom_range(smrl_pkg::SET_DEPTH + 1, smrl_pkg::SET_DEPTH + 4);
            for (int k = 0; k < count; k++) begin
               push_item(smrl_pkg::MODE_ADDSET, base + k, $urandom);
            end
            if ($urandom_range(0, 2) == 0) push_item(smrl_pkg::MODE_CLEAR, $urandom, $urandom);
            push_query(50);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/smrl_pkg.sv
design/smrl_req_if.sv
design/smrl_rsp_if.sv
design/set_membership_run_length.sv
verif/set_membership_run_length_tb.sv
